/* rtl/asa_pkg.sv */
// ============================================================================
// asa_pkg: shared types and constants for the aligned stack allocator
// Request and result payloads, register indexes, status codes and reset
// values used by the allocator core and its arithmetic unit.
// ============================================================================
package asa_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

    // Register reset values
    localparam logic [31:0] POOL_SIZE_RST    = 32'd65536;
    localparam logic [12:0] HEADER_BYTES_RST = 13'd24;
    localparam logic [31:0] BASE_ADDRESS_RST = 32'd0;

    // Marker slot: 8-byte aligned, 8 bytes long (alignof/sizeof of s64)
    localparam int MARKER_ALIGN = 8;
    localparam int MARKER_BYTES = 8;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOSPACE   = 3'd1;
    localparam logic [2:0] ST_ZEROALIGN = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Mode codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] count;
        logic [31:0] elem_size;
        logic [15:0] align;
    } asa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] address;
        logic [31:0] freed_bytes;
    } asa_rsp_t;

    // Arithmetic unit control and status
    typedef struct packed {
        logic go;
        logic div;
    } asa_mdu_ctl_t;

    typedef struct packed {
        logic        done;
        logic [15:0] rem;
        logic [63:0] prod;
    } asa_mdu_sts_t;

endpackage

/* rtl/asa_ram.sv */
// ============================================================================
// asa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module asa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/asa_mdu.sv */
// ============================================================================
// asa_mdu: shared iterative multiply / remainder unit
// One 33-bit adder, one bit per cycle. Multiply gives the 64-bit product
// of two 32-bit operands; divide gives the remainder of a 32-bit dividend
// by a 16-bit divisor.
// ============================================================================
module asa_mdu
    import asa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  asa_mdu_ctl_t ctl,
    input  logic [31:0]  opa,
    input  logic [31:0]  opb,
    output asa_mdu_sts_t sts
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg,  div_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [31:0]      acc_reg,  acc_next;
    logic [31:0]      shq_reg,  shq_next;
    logic [31:0]      opb_reg,  opb_next;

    logic [32:0] add_a;
    logic [32:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;

    // Shared adder: add for multiply, subtract for remainder trial
    always_comb
    begin
        if (div_reg)
        begin
            add_a   = {acc_reg, shq_reg[31]};
            add_b   = ~{1'b0, opb_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, acc_reg};
            add_b   = shq_reg[0] ? {1'b0, opb_reg} : 33'd0;
            add_cin = 1'b0;
        end
        add_sum = add_a + add_b + {32'd0, add_cin};
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        shq_next  = shq_reg;
        opb_next  = opb_reg;
        if (ctl.go)
        begin
            busy_next = 1'b1;
            div_next  = ctl.div;
            cnt_next  = '0;
            acc_next  = '0;
            shq_next  = opa;
            opb_next  = opb;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (div_reg)
            begin
                // restoring step: keep trial difference when no borrow
                acc_next = add_sum[32] ? add_a[31:0] : add_sum[31:0];
                shq_next = {shq_reg[30:0], 1'b0};
            end
            else
            begin
                acc_next = add_sum[32:1];
                shq_next = {add_sum[0], shq_reg[31:1]};
            end
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        shq_reg <= shq_next;
        opb_reg <= opb_next;
    end

    assign sts.done = done_reg;
    assign sts.rem  = acc_reg[15:0];
    assign sts.prod = {acc_reg, shq_reg};

endmodule

/* rtl/aligned_stack_allocator_core.sv */
// ============================================================================
// aligned_stack_allocator_core: LIFO pool allocator with marker stack
// A transaction is taken when start is high and busy is low; its result
// appears on result for exactly one cycle with done high, and cannot be
// held off. The rounding of an allocate's occupied offset needs a
// remainder and its size a multiply, both on one shared 1-bit-per-cycle
// adder unit. A free does one marker stack read; a zero alignment or an
// empty-stack free answers straight from idle, with busy kept low; else
// busy stays high until done. Config writes must go in only while busy is
// low; the block itself does not enforce this.
// ============================================================================
module aligned_stack_allocator_core
    import asa_pkg::*;
#(
    parameter int MARK_DEPTH = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  asa_req_t              request,
    // result channel
    output logic                  done,
    output asa_rsp_t              result,
    // configuration port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MAW   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int CNT_W = $clog2(MARK_DEPTH + 1);
    localparam logic [33:0] ADDR_MASK =
        (ADDR_BITS >= 34) ? {34{1'b1}} : ((34'd1 << ADDR_BITS) - 34'd1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_MUL   = 6'b000100,
        S_SUM   = 6'b001000,
        S_CHECK = 6'b010000,
        S_POP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers; header_bytes only acts on the occupied offset
    // at the write itself, so it needs no storage of its own
    logic [31:0] pool_size_reg;
    logic [31:0] base_address_reg;

    // Allocator state
    logic [31:0]      occ_reg,   occ_next;
    logic [CNT_W-1:0] mcount_reg, mcount_next;

    // Transaction working registers
    logic [31:0] count_reg,  count_next;
    logic [31:0] esize_reg,  esize_next;
    logic [15:0] align_reg,  align_next;
    logic [32:0] start_reg,  start_next;
    logic [65:0] end_reg,    end_next;

    // Result register
    logic     done_reg, done_next;
    asa_rsp_t rsp_reg,  rsp_next;

    // Arithmetic unit
    asa_mdu_ctl_t mdu_ctl;
    asa_mdu_sts_t mdu_sts;
    logic [31:0]  mdu_opa;
    logic [31:0]  mdu_opb;

    // Marker RAM
    logic           ram_we;
    logic [MAW-1:0] ram_waddr;
    logic           ram_re;
    logic [MAW-1:0] ram_raddr;
    logic [31:0]    ram_rdata;

    logic        accept;
    logic        mark_full;
    logic        no_space;
    logic [33:0] addr_sum;

    assign accept    = start && state_reg == S_IDLE;
    assign mark_full = mcount_reg == CNT_W'(MARK_DEPTH);
    assign no_space  = end_reg > {34'd0, pool_size_reg};
    assign addr_sum  = ({2'b0, base_address_reg} + {1'b0, start_reg}) & ADDR_MASK;

    asa_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mdu_ctl),
        .opa   (mdu_opa),
        .opb   (mdu_opb),
        .sts   (mdu_sts)
    );

    asa_ram #(
        .WIDTH (32),
        .DEPTH (MARK_DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (occ_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        mcount_next = mcount_reg;
        count_next  = count_reg;
        esize_next  = esize_reg;
        align_next  = align_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mdu_ctl     = '0;
        mdu_opa     = count_reg;
        mdu_opb     = esize_reg;
        ram_we      = 1'b0;
        ram_waddr   = mcount_reg[MAW-1:0];
        ram_re      = 1'b0;
        ram_raddr   = MAW'(mcount_reg - 1'b1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = request.count;
                    esize_next = request.elem_size;
                    align_next = request.align;
                    if (request.mode == MODE_FREE)
                    begin
                        if (mcount_reg == '0)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: ST_EMPTY, address: '0,
                                          freed_bytes: '0};
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    else if (request.align == '0)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{status: ST_ZEROALIGN, address: '0,
                                      freed_bytes: '0};
                    end
                    else
                    begin
                        // occupied mod align
                        mdu_ctl.go  = 1'b1;
                        mdu_ctl.div = 1'b1;
                        mdu_opa     = occ_reg;
                        mdu_opb     = {16'd0, request.align};
                        state_next  = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (mdu_sts.done)
                begin
                    if (mdu_sts.rem == '0)
                    begin
                        start_next = {1'b0, occ_reg};
                    end
                    else
                    begin
                        start_next = {1'b0, occ_reg} + {17'd0, align_reg - mdu_sts.rem};
                    end
                    // count * elem_size
                    mdu_ctl.go  = 1'b1;
                    mdu_ctl.div = 1'b0;
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                if (mdu_sts.done)
                begin
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                // round data end up to the marker alignment, add the marker slot
                end_next = ({33'd0, start_reg} + {2'b0, mdu_sts.prod}
                            + 66'(MARKER_ALIGN - 1 + MARKER_BYTES))
                           & ~66'(MARKER_ALIGN - 1);
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (no_space)
                begin
                    rsp_next = '{status: ST_NOSPACE, address: '0, freed_bytes: '0};
                end
                else if (mark_full)
                begin
                    rsp_next = '{status: ST_FULL, address: '0, freed_bytes: '0};
                end
                else
                begin
                    ram_we      = 1'b1;
                    mcount_next = mcount_reg + 1'b1;
                    occ_next    = end_reg[31:0];
                    rsp_next    = '{status: ST_OK, address: addr_sum[31:0],
                                    freed_bytes: '0};
                end
            end

            S_POP:
            begin
                done_next   = 1'b1;
                state_next  = S_IDLE;
                mcount_next = mcount_reg - 1'b1;
                occ_next    = ram_rdata;
                rsp_next    = '{status: ST_OK, address: '0,
                                freed_bytes: occ_reg - ram_rdata};
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // header write moves the occupied offset while nothing is allocated
        if (cfg_we && cfg_index == REG_HEADER_BYTES && mcount_reg == '0)
        begin
            occ_next = {19'd0, cfg_data[12:0]};
        end
    end

    // Control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= {19'd0, HEADER_BYTES_RST};
            mcount_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            mcount_reg <= mcount_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        esize_reg <= esize_next;
        align_reg <= align_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        rsp_reg   <= rsp_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg    <= POOL_SIZE_RST;
            base_address_reg <= BASE_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_SIZE:    pool_size_reg    <= cfg_data;
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
